>>> rtl/core/epc_pkg.sv
// Shared constants for the equal-power pan crossfade block.
// Used by the top level and by the divider and square-root units.
package epc_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_WIDTH = 16;
   localparam int LENGTH_WIDTH = 16;
   localparam int GAIN_WIDTH   = 16;

   // Quotient of num^2 * 2^30 / (a^2 + b^2): at most 2^30, so 31 bits.
   localparam int QUOT_WIDTH   = 31;

   // Default width of the position counter.
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Reset value of the transition length register.
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = 16'd1024;

   // Unity gain in unsigned Q1.15 and its square in the quotient domain.
   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = 16'h8000;
   localparam logic [QUOT_WIDTH-1:0] QUOT_ONE = 31'h4000_0000;

endpackage

>>> rtl/core/epc_serial_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Stand-alone; no package dependencies.
module epc_serial_mul #(
   parameter int WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIDTH-1:0]     mcand,
   input  logic [WIDTH-1:0]     mplier,
   output logic                 done,
   output logic [2*WIDTH-1:0]   product
);

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [WIDTH-1:0]     mcand_ff;
   logic [WIDTH-1:0]     hi_ff;
   logic [WIDTH-1:0]     lo_ff;
   logic [WIDTH:0]       partial_in;

   // Add the multiplicand when the current multiplier bit is set.
   always_comb begin
      partial_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_WIDTH'(WIDTH - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(WIDTH - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Product shifts right one bit a cycle; the multiplier drains from the low half.
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         hi_ff    <= '0;
         lo_ff    <= mplier;
      end else if (busy_ff) begin
         hi_ff <= partial_in[WIDTH:1];
         lo_ff <= {partial_in[0], lo_ff[WIDTH-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

>>> rtl/core/epc_divider.sv
// Restoring divider giving floor(num^2 * 2^30 / sum), one quotient bit per cycle.
// Depends on epc_pkg for the quotient width.
module epc_divider #(
   parameter int COUNT_WIDTH = epc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [2*COUNT_WIDTH-1:0]        numer_sq,
   input  logic [2*COUNT_WIDTH:0]          divisor,
   output logic                            done,
   output logic [epc_pkg::QUOT_WIDTH-1:0]  quotient,
   output logic                            rem_nonzero
);

   localparam int DIV_WIDTH = 2 * COUNT_WIDTH + 1;
   localparam int REM_WIDTH = DIV_WIDTH + 1;
   localparam int QW        = epc_pkg::QUOT_WIDTH;
   localparam int CNT_WIDTH = $clog2(QW + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [REM_WIDTH-1:0] rem_ff;
   logic [DIV_WIDTH-1:0] divisor_ff;
   logic [QW-1:0]        quot_ff;
   logic                 ge;
   logic [REM_WIDTH-1:0] rem_sub;
   logic [REM_WIDTH-1:0] rem_in;
   logic [QW-1:0]        quot_in;

   // One compare and subtract per step; the remainder then doubles.
   always_comb begin
      ge      = rem_ff >= {1'b0, divisor_ff};
      rem_sub = ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;
      rem_in  = {rem_sub[REM_WIDTH-2:0], 1'b0};
      quot_in = {quot_ff[QW-2:0], ge};
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_WIDTH'(QW - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(QW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // The dividend starts as num^2; the 2^30 factor enters as the doublings.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= {2'b00, numer_sq};
         divisor_ff <= divisor;
         quot_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign done        = done_ff;
   assign quotient    = quot_ff;
   assign rem_nonzero = rem_ff != '0;

endmodule

>>> rtl/core/epc_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on epc_pkg for the quotient and gain widths.
module epc_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [epc_pkg::QUOT_WIDTH-1:0]  radicand,
   output logic                            done,
   output logic [epc_pkg::GAIN_WIDTH-1:0]  root
);

   localparam int GW        = epc_pkg::GAIN_WIDTH;
   localparam int RAD_WIDTH = 2 * GW;
   localparam int REM_WIDTH = GW + 4;
   localparam int CNT_WIDTH = $clog2(GW + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [RAD_WIDTH-1:0] rad_ff;
   logic [REM_WIDTH-1:0] rem_ff;
   logic [GW-1:0]        root_ff;
   logic [REM_WIDTH-1:0] rem_shift;
   logic [REM_WIDTH-1:0] trial;
   logic                 ge;
   logic [REM_WIDTH-1:0] rem_in;
   logic [GW-1:0]        root_in;

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      rem_shift = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1:RAD_WIDTH-2]};
      trial     = REM_WIDTH'({root_ff, 2'b01});
      ge        = rem_shift >= trial;
      rem_in    = ge ? (rem_shift - trial) : rem_shift;
      root_in   = {root_ff[GW-2:0], ge};
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CNT_WIDTH'(GW - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(GW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Radicand shifts out two bits a step.
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= RAD_WIDTH'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_WIDTH-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/core/equal_power_pan_crossfade.sv
// Equal-power pan sweep: splits each mono sample into left and right outputs.
// Depends on epc_pkg, epc_serial_mul, epc_divider and epc_isqrt.
//
// Each sample goes in turn through a chain of bit-serial units: squaring of
// the two distances, a restoring divide, two parallel square roots and two
// parallel scaling multiplies. A new sample is accepted only once the last
// one has reached the output register, where a finished result waits while
// the next sample is accepted. The gains are exact: floor(32768 * num /
// sqrt(a^2 + b^2)), with a length of 0 treated as 1 and a position left
// beyond the end by a length write taken as the last sample.
module equal_power_pan_crossfade #(
   parameter int COUNT_WIDTH = epc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Input sample channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [epc_pkg::SAMPLE_WIDTH-1:0]   req_sample_in,
   // Result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [epc_pkg::SAMPLE_WIDTH-1:0]   rsp_left_sample,
   output logic signed [epc_pkg::SAMPLE_WIDTH-1:0]   rsp_right_sample,
   output logic                                      rsp_transition_end,
   // Configuration write channel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [epc_pkg::LENGTH_WIDTH-1:0]          csr_transition_length
);

   localparam int SW        = epc_pkg::SAMPLE_WIDTH;
   localparam int LW        = epc_pkg::LENGTH_WIDTH;
   localparam int GW        = epc_pkg::GAIN_WIDTH;
   localparam int QW        = epc_pkg::QUOT_WIDTH;
   localparam int SQ_WIDTH  = 2 * COUNT_WIDTH;
   localparam int EXT_WIDTH = (COUNT_WIDTH > LW) ? COUNT_WIDTH : LW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_ROOT,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

   state_type              state_ff;
   logic                   rsp_valid_ff;
   logic [SW-1:0]          rsp_left_ff;
   logic [SW-1:0]          rsp_right_ff;
   logic                   rsp_end_ff;

   logic [LW-1:0]          length_ff;
   logic [COUNT_WIDTH-1:0] position_ff;
   logic [COUNT_WIDTH-1:0] position_in;
   logic                   last_ff;
   logic                   sample_neg_ff;
   logic [SW-1:0]          sample_mag_ff;
   logic                   special_ff;

   logic                   accept;
   logic                   out_free;
   logic [EXT_WIDTH-1:0]   len_m1_ext;
   logic [EXT_WIDTH-1:0]   k_max_ext;
   logic [EXT_WIDTH-1:0]   nm1_ext;
   logic [COUNT_WIDTH-1:0] nm1;
   logic                   is_last;
   logic [COUNT_WIDTH-1:0] k_eff;
   logic [COUNT_WIDTH-1:0] dist_a;
   logic [COUNT_WIDTH-1:0] dist_b;

   logic                   sq_a_done;
   logic                   sq_b_done;
   logic                   sq_done;
   logic [SQ_WIDTH-1:0]    sq_a;
   logic [SQ_WIDTH-1:0]    sq_b;
   logic [SQ_WIDTH:0]      sum_sq;

   logic                   div_done;
   logic [QW-1:0]          div_quot;
   logic                   div_rem_nz;
   logic [QW-1:0]          quot_l;
   logic [QW-1:0]          quot_r;

   logic                   root_l_done;
   logic                   root_r_done;
   logic                   root_done;
   logic [GW-1:0]          gain_l;
   logic [GW-1:0]          gain_r;

   logic                   scale_l_done;
   logic                   scale_r_done;
   logic                   scale_done;
   logic [2*SW-1:0]        prod_l;
   logic [2*SW-1:0]        prod_r;
   logic [SW-1:0]          mag_l;
   logic [SW-1:0]          mag_r;
   logic [SW-1:0]          left_in;
   logic [SW-1:0]          right_in;

   // Handshakes.
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Effective end position n-1, clamped to the counter range; a zero length acts as one.
   always_comb begin
      len_m1_ext = (length_ff == '0) ? '0 : EXT_WIDTH'(length_ff - 1'b1);
      k_max_ext  = EXT_WIDTH'({COUNT_WIDTH{1'b1}});
      nm1_ext    = (len_m1_ext > k_max_ext) ? k_max_ext : len_m1_ext;
      nm1        = nm1_ext[COUNT_WIDTH-1:0];
      is_last    = position_ff >= nm1;
      k_eff      = is_last ? nm1 : position_ff;
      dist_a     = nm1 - k_eff;
      dist_b     = k_eff;
      position_in = is_last ? '0 : (position_ff + 1'b1);
   end

   // Length register and position counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= epc_pkg::LENGTH_RESET;
         position_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            length_ff <= csr_transition_length;
         end
         if (accept) begin
            position_ff <= position_in;
         end
      end
   end

   // Per-sample operands held for the length of the computation.
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff       <= is_last;
         sample_neg_ff <= req_sample_in[SW-1];
         sample_mag_ff <= req_sample_in[SW-1] ? SW'(~req_sample_in + 1'b1)
                                              : req_sample_in;
      end
      if (sq_done) begin
         special_ff <= (sum_sq == '0);
      end
   end

   // Squares of the two distances.
   epc_serial_mul #(.WIDTH(COUNT_WIDTH)) u_sq_a (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (dist_a),
      .mplier  (dist_a),
      .done    (sq_a_done),
      .product (sq_a)
   );

   epc_serial_mul #(.WIDTH(COUNT_WIDTH)) u_sq_b (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (dist_b),
      .mplier  (dist_b),
      .done    (sq_b_done),
      .product (sq_b)
   );

   assign sq_done = sq_a_done & sq_b_done;
   assign sum_sq  = {1'b0, sq_a} + {1'b0, sq_b};

   // Left quotient a^2 * 2^30 / sum; the right one follows from it and the remainder.
   epc_divider #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (sq_done),
      .numer_sq    (sq_a),
      .divisor     (sum_sq),
      .done        (div_done),
      .quotient    (div_quot),
      .rem_nonzero (div_rem_nz)
   );

   // The two quotients add to 2^30 less one when the division is inexact.
   // A single-sample transition forces unity left gain and zero right gain.
   always_comb begin
      quot_l = special_ff ? epc_pkg::QUOT_ONE : div_quot;
      quot_r = special_ff ? '0
                          : (epc_pkg::QUOT_ONE - div_quot - QW'(div_rem_nz));
   end

   // Gains are the square roots of the quotients.
   epc_isqrt u_root_l (
      .clock    (clock),
      .reset    (reset),
      .start    (div_done),
      .radicand (quot_l),
      .done     (root_l_done),
      .root     (gain_l)
   );

   epc_isqrt u_root_r (
      .clock    (clock),
      .reset    (reset),
      .start    (div_done),
      .radicand (quot_r),
      .done     (root_r_done),
      .root     (gain_r)
   );

   assign root_done = root_l_done & root_r_done;

   // Sample magnitude times each gain.
   epc_serial_mul #(.WIDTH(SW)) u_scale_l (
      .clock   (clock),
      .reset   (reset),
      .start   (root_done),
      .mcand   (sample_mag_ff),
      .mplier  (gain_l),
      .done    (scale_l_done),
      .product (prod_l)
   );

   epc_serial_mul #(.WIDTH(SW)) u_scale_r (
      .clock   (clock),
      .reset   (reset),
      .start   (root_done),
      .mcand   (sample_mag_ff),
      .mplier  (gain_r),
      .done    (scale_r_done),
      .product (prod_r)
   );

   assign scale_done = scale_l_done & scale_r_done;

   // Drop the 15 fraction bits and restore the sign, which truncates toward zero.
   always_comb begin
      mag_l    = prod_l[SW+GW-2:GW-1];
      mag_r    = prod_r[SW+GW-2:GW-1];
      left_in  = sample_neg_ff ? SW'(~mag_l + 1'b1) : mag_l;
      right_in = sample_neg_ff ? SW'(~mag_r + 1'b1) : mag_r;
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output register refills in the cycle its old transaction leaves.
         if ((state_ff == ST_OUTPUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               if (sq_done) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_done) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (scale_done) begin
                  state_ff <= ST_OUTPUT;
               end
            end
            ST_OUTPUT: begin
               if (out_free) begin
                  rsp_left_ff  <= left_in;
                  rsp_right_ff <= right_in;
                  rsp_end_ff   <= last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_sample    = rsp_left_ff;
   assign rsp_right_sample   = rsp_right_ff;
   assign rsp_transition_end = rsp_end_ff;

`ifndef SYNTHESIS
   // Paired units run in lockstep.
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      (sq_a_done == sq_b_done) && (root_l_done == root_r_done) &&
      (scale_l_done == scale_r_done))
      else $error("paired serial units finished in different cycles");

   // Gains never exceed unity.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (gain_l <= epc_pkg::GAIN_ONE) && (gain_r <= epc_pkg::GAIN_ONE))
      else $error("gain above unity");

   // One sample in flight: the input closes right after a transaction.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("input accepted while a sample is in flight");

   // The last sample of a transition restarts the position.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && is_last) |=> (position_ff == '0))
      else $error("position did not restart after the last sample");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for equal_power_pan_crossfade: a directed table, then random samples and lengths.
// Depends on epc_pkg and the equal_power_pan_crossfade RTL.
module tb;

   // One result transaction: left, right and the end-of-transition flag.
   typedef struct packed {
      logic [epc_pkg::SAMPLE_WIDTH-1:0] left;
      logic [epc_pkg::SAMPLE_WIDTH-1:0] right;
      logic                             tend;
   } pan_result_type;

   // One row of directed stimulus, with an optional length write before it.
   typedef struct packed {
      logic                             cfg_write;
      logic [epc_pkg::LENGTH_WIDTH-1:0] cfg_len;
      logic [epc_pkg::SAMPLE_WIDTH-1:0] sample;
      logic                             typed;
      pan_result_type                   result;
   } pan_row_type;

   localparam int NUM_ROWS   = 22;
   localparam int NUM_PHASES = 16;
   localparam int PHASE_ITEMS = 82;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [epc_pkg::SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [epc_pkg::SAMPLE_WIDTH-1:0] rsp_left_sample;
   logic signed [epc_pkg::SAMPLE_WIDTH-1:0] rsp_right_sample;
   logic rsp_transition_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [epc_pkg::LENGTH_WIDTH-1:0] csr_transition_length = '0;

   // Model state of the sweep and the results still owed by the block.
   logic [epc_pkg::LENGTH_WIDTH-1:0] pan_length = epc_pkg::LENGTH_RESET;
   logic [15:0]             pan_position = '0;
   pan_result_type          pending_pans [$];
   int                      mismatch_count = 0;
   int                      send_idle_pct = 0;
   int                      rsp_stall_pct = 0;

   // Directed rows: reset length, single-sample and zero length, short sweeps,
   // a stale position after shortening the length, and the longest length.
   pan_row_type sweep_rows [NUM_ROWS] = '{
      '{1'b0, 16'd0,     16'h7FFF, 1'b1, '{16'h7FFF, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'h8000, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b1, 16'd1,     16'h8000, 1'b1, '{16'h8000, 16'h0000, 1'b1}},
      '{1'b0, 16'd0,     16'h7FFF, 1'b1, '{16'h7FFF, 16'h0000, 1'b1}},
      '{1'b0, 16'd0,     16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
      '{1'b1, 16'd0,     16'hFFFF, 1'b1, '{16'hFFFF, 16'h0000, 1'b1}},
      '{1'b1, 16'd2,     16'd12345, 1'b1, '{16'd12345, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'h8000, 1'b1, '{16'h0000, 16'h8000, 1'b1}},
      '{1'b1, 16'd3,     16'h8000, 1'b1, '{16'h8000, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'h7FFF, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'h7FFF, 1'b1, '{16'h0000, 16'h7FFF, 1'b1}},
      '{1'b0, 16'd0,     16'd7,    1'b1, '{16'd7,    16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'hFFFF, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'd100,  1'b1, '{16'h0000, 16'd100,  1'b1}},
      '{1'b1, 16'd5,     16'h5555, 1'b1, '{16'h5555, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'hAAAA, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'h7FFF, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b1, 16'd2,     16'd1000, 1'b1, '{16'h0000, 16'd1000, 1'b1}},
      '{1'b0, 16'd0,     16'hFC18, 1'b1, '{16'hFC18, 16'h0000, 1'b0}},
      '{1'b1, 16'd65535, 16'd1,    1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'hFFFE, 1'b0, '{16'h0000, 16'h0000, 1'b0}},
      '{1'b0, 16'd0,     16'h8000, 1'b0, '{16'h0000, 16'h0000, 1'b0}}
   };

   equal_power_pan_crossfade DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample_in         (req_sample_in),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_left_sample       (rsp_left_sample),
      .rsp_right_sample      (rsp_right_sample),
      .rsp_transition_end    (rsp_transition_end),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_transition_length (csr_transition_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Largest Q1.15 gain g in [0, 1.0] with g*g*sum <= 2^30 * num*num.
   function automatic longint unsigned unit_gain(input longint unsigned num,
                                                 input longint unsigned sum);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned bound;
      lo = 0;
      hi = 32768;
      bound = (num * num) << 30;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid * sum <= bound) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   // Sample times gain, shifted down by 15 with truncation toward zero.
   function automatic logic [15:0] apply_gain(input logic signed [15:0] s,
                                              input longint unsigned g);
      longint prod;
      longint quot;
      prod = longint'(s) * longint'(g);
      quot = prod / 64'sd32768;
      return quot[15:0];
   endfunction

   // Works out the result of one sample and advances the sweep position.
   task automatic predict_pan(input logic [15:0] s, output pan_result_type r);
      longint unsigned n;
      longint unsigned k;
      longint unsigned a;
      longint unsigned b;
      longint unsigned gl;
      longint unsigned gr;
      bit              last;
      n = 64'(pan_length);
      if (n == 0) begin
         n = 1;
      end
      k = 64'(pan_position);
      // A position left past the end by a length write ends the sweep now.
      last = (k >= n - 1);
      if (last) begin
         k = n - 1;
      end
      a = n - 1 - k;
      b = k;
      if (a == 0 && b == 0) begin
         gl = 32768;
         gr = 0;
      end else begin
         gl = unit_gain(a, a * a + b * b);
         gr = unit_gain(b, a * a + b * b);
      end
      r.left = apply_gain(s, gl);
      r.right = apply_gain(s, gr);
      r.tend = last;
      pan_position = last ? 16'd0 : 16'(k + 1);
   endtask

   // Offers one sample after a random gap and records what it must produce.
   task automatic send_sample(input logic [15:0] s, input bit typed,
                              input pan_result_type typed_r);
      pan_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (!req_ready);
      predict_pan(s, r);
      pending_pans.push_back(typed ? typed_r : r);
   endtask

   // Writes the length once the block has delivered every owed result.
   task automatic write_length(input logic [15:0] len);
      req_valid <= 1'b0;
      while (pending_pans.size() != 0) begin
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_transition_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pan_length = len;
   endtask

   // Result side: random stalls, and each transaction checked in order.
   task automatic check_result();
      pan_result_type want;
      if (pending_pans.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("Unexpected result: left %0d right %0d end %0b",
                     rsp_left_sample, rsp_right_sample, rsp_transition_end);
         end
      end else begin
         want = pending_pans.pop_front();
         if (rsp_left_sample !== want.left || rsp_right_sample !== want.right ||
             rsp_transition_end !== want.tend) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Mismatch: expected left %0d right %0d end %0b, got %0d %0d %0b",
                        $signed(want.left), $signed(want.right), want.tend,
                        rsp_left_sample, rsp_right_sample, rsp_transition_end);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         check_result();
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      logic [15:0] len;
      logic [15:0] s;
      pan_result_type none;
      none = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, starting from the reset length.
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (sweep_rows[i].cfg_write) begin
            write_length(sweep_rows[i].cfg_len);
         end
         send_sample(sweep_rows[i].sample, sweep_rows[i].typed, sweep_rows[i].result);
      end

      // Random part: a new length and idling pattern per phase.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 8)
            0: len = 16'd1;
            1: len = 16'd65535;
            2: len = 16'd0;
            3: len = 16'd2;
            4: len = 16'($urandom_range(12, 3));
            5: len = 16'($urandom_range(40, 1));
            6: len = 16'($urandom);
            default: len = 16'd3;
         endcase
         write_length(len);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 48;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 48;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct = 18;
            end
         endcase
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            case ($urandom_range(19))
               0: s = 16'h8000;
               1: s = 16'h7FFF;
               2: s = 16'hFFFF;
               3: s = 16'h0000;
               default: s = 16'($urandom);
            endcase
            send_sample(s, 1'b0, none);
         end
      end

      // Let every owed result arrive, then watch for stray ones.
      req_valid <= 1'b0;
      while (pending_pans.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_pans.size() == 0) begin
         $display("equal_power_pan_crossfade test passed");
      end else begin
         $display("equal_power_pan_crossfade test failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("equal_power_pan_crossfade test failed");
      $finish;
   end

endmodule
